[rtl/mandelbrot_escape_colorizer_unit_defines.svh]
// Assertion macros for the escape-time colouriser.
// Expect clk and rst_n in the scope that uses them; no other dependencies.
`ifndef MANDELBROT_ESCAPE_COLORIZER_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_COLORIZER_UNIT_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define MEC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset.
`define MEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mec_pkg.sv]
// Shared types, constants and the colour palette of the escape-time colouriser.
// No dependencies; every RTL module imports it.
`default_nettype none

package mec_pkg;

  localparam int ITER_W     = 13;
  localparam int COORD_W    = 32;
  localparam int Z_W        = 31;
  localparam int ZN_W       = 34;
  localparam int SQ_W       = 59;
  localparam int XP_W       = 60;
  localparam int DIV_W      = 20;
  localparam int DEN_W      = 13;
  localparam int DIV_STEPS  = 20;
  localparam int SQRT_STEPS = 13;
  localparam int RAD_W      = 26;
  localparam int SQREM_W    = 16;

  localparam logic [1:0] REG_MAX_ITER     = 2'd0;
  localparam logic [1:0] REG_COLOR_SCHEME = 2'd1;

  localparam logic [1:0] SCHEME_NONE   = 2'd0;
  localparam logic [1:0] SCHEME_GREY   = 2'd1;
  localparam logic [1:0] SCHEME_SQRT   = 2'd2;
  localparam logic [1:0] SCHEME_LINEAR = 2'd3;

  localparam logic [ITER_W-1:0] LIM_MIN   = 13'd2;
  localparam logic [ITER_W-1:0] LIM_MAX   = 13'd4096;
  localparam logic [ITER_W-1:0] LIM_RESET = 13'd256;

  localparam logic [DEN_W-1:0] PAL_STRIDE = 13'd14;
  localparam logic [3:0]       PAL_LAST   = 4'd14;

  // lim / 14 as (lim * ceil(2^16 / 14)) >> 16, exact for every limit up to 4096
  localparam logic [ITER_W-1:0] PAL_RECIP    = 13'd4682;
  localparam int                PAL_RECIP_SH = 16;

  // 2.0 in Q4.28, and 4.0 in the Q.56 squares
  localparam logic signed [COORD_W-1:0] C_BOUND   = 32'sd536870912;
  localparam logic signed [COORD_W-1:0] C_BOUND_N = -32'sd536870912;
  localparam logic signed [ZN_W-1:0]    Z_BOUND   = 34'sd536870912;
  localparam logic signed [ZN_W-1:0]    Z_BOUND_N = -34'sd536870912;
  localparam logic [XP_W-1:0]           NORM_FOUR = 60'h400000000000000;

  typedef struct packed {
    logic                       early;
    logic signed [COORD_W-1:0]  c_real;
    logic signed [COORD_W-1:0]  c_imag;
  } mec_item_t;

  typedef struct packed {
    logic              valid;
    logic [ITER_W-1:0] count;
  } mec_count_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } mec_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } mec_div_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [ITER_W-1:0] count;
  } mec_pixel_t;

  typedef enum logic [1:0] {
    IT_IDLE,
    IT_ADD,
    IT_MUL,
    IT_HOLD
  } iter_state_t;

  typedef enum logic [3:0] {
    SH_IDLE,
    SH_PROD,
    SH_SQRT,
    SH_PICK,
    SH_IDX_GO,
    SH_IDX_WAIT,
    SH_GREY_GO,
    SH_GREY_WAIT,
    SH_OUT
  } shade_state_t;

  // {red, green, blue}; the last entry is black
  function automatic logic [23:0] pal_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'hFFFFFF;
      4'd1:    rgb = 24'hFF0000;
      4'd2:    rgb = 24'hFF8000;
      4'd3:    rgb = 24'hFFFF00;
      4'd4:    rgb = 24'h80FF00;
      4'd5:    rgb = 24'h00FF00;
      4'd6:    rgb = 24'h00FF80;
      4'd7:    rgb = 24'h00FFFF;
      4'd8:    rgb = 24'h0080FF;
      4'd9:    rgb = 24'h0000FF;
      4'd10:   rgb = 24'h8000E1;
      4'd11:   rgb = 24'hFF00FF;
      4'd12:   rgb = 24'hFF0080;
      4'd13:   rgb = 24'h808080;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

[rtl/mec_front.sv]
// Front end: takes a point on the command port, flags points that escape at once.
// Depends on mec_pkg.
`default_nettype none

module mec_front import mec_pkg::*; (
  input  wire logic                      start,
  input  wire logic signed [COORD_W-1:0] in_c_real,
  input  wire logic signed [COORD_W-1:0] in_c_imag,
  input  wire logic                      queue_full,
  output logic                           busy,
  output logic                           push,
  output mec_item_t                      push_item
);

  logic far_real;
  logic far_imag;

  // a component beyond +/-2 escapes on the first step
  assign far_real = (in_c_real > C_BOUND) || (in_c_real < C_BOUND_N);
  assign far_imag = (in_c_imag > C_BOUND) || (in_c_imag < C_BOUND_N);

  assign busy             = queue_full;
  assign push             = start && !queue_full;
  assign push_item.early  = far_real || far_imag;
  assign push_item.c_real = in_c_real;
  assign push_item.c_imag = in_c_imag;

endmodule

`default_nettype wire

[rtl/mec_fifo.sv]
// Two-entry queue between the front end and the iteration engine.
// Depends on mec_pkg.
`default_nettype none

module mec_fifo import mec_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire mec_item_t push_item,
  input  wire logic      pop,
  output logic           full,
  output logic           head_valid,
  output mec_item_t      head_item
);

  mec_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[rtl/mec_iter.sv]
// Iteration engine: z = z*z + c in Q4.28, each step a multiply state then an add state.
// Depends on mec_pkg.
`default_nettype none

module mec_iter import mec_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire mec_item_t         head_item,
  output logic                   pop,
  input  wire logic [ITER_W-1:0] lim,
  input  wire logic              shade_ready,
  output mec_count_t             done
);

  iter_state_t              state_r, state_nxt;
  logic signed [Z_W-1:0]    zr_r, zr_nxt;
  logic signed [Z_W-1:0]    zi_r, zi_nxt;
  logic signed [Z_W-1:0]    cr_r, cr_nxt;
  logic signed [Z_W-1:0]    ci_r, ci_nxt;
  logic [SQ_W-1:0]          sqr_r, sqr_nxt;
  logic [SQ_W-1:0]          sqi_r, sqi_nxt;
  logic signed [XP_W-1:0]   xp_r, xp_nxt;
  logic [ITER_W-1:0]        iter_r, iter_nxt;

  logic signed [2*Z_W-1:0]  prod_rr;
  logic signed [2*Z_W-1:0]  prod_ii;
  logic signed [2*Z_W-1:0]  prod_ri;
  logic [XP_W-1:0]          norm;
  logic signed [XP_W-1:0]   diff;
  logic signed [ZN_W-1:0]   zr_new;
  logic signed [ZN_W-1:0]   zi_new;
  logic                     esc_norm;
  logic                     esc_range;
  logic                     at_lim;

  assign prod_rr = zr_r * zr_r;
  assign prod_ii = zi_r * zi_r;
  assign prod_ri = zr_r * zi_r;

  // exact |z|^2 of the z produced in the previous add cycle
  assign norm     = {1'b0, sqr_r} + {1'b0, sqi_r};
  assign esc_norm = (norm > NORM_FOUR);
  assign at_lim   = (iter_r == lim);

  // arithmetic shift gives the floor; the cross term is doubled by shifting one less
  assign diff   = $signed({1'b0, sqr_r}) - $signed({1'b0, sqi_r});
  assign zr_new = {{2{diff[XP_W-1]}}, diff[XP_W-1:28]} + {{3{cr_r[Z_W-1]}}, cr_r};
  assign zi_new = {xp_r[XP_W-1], xp_r[XP_W-1:27]} + {{3{ci_r[Z_W-1]}}, ci_r};

  assign esc_range = (zr_new > Z_BOUND) || (zr_new < Z_BOUND_N) ||
                     (zi_new > Z_BOUND) || (zi_new < Z_BOUND_N);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      IT_IDLE: begin
        if (head_valid) begin
          state_nxt = head_item.early ? IT_HOLD : IT_ADD;
        end
      end
      IT_ADD: begin
        if (esc_norm || at_lim || esc_range) begin
          state_nxt = IT_HOLD;
        end else begin
          state_nxt = IT_MUL;
        end
      end
      IT_MUL: begin
        state_nxt = IT_ADD;
      end
      IT_HOLD: begin
        if (shade_ready) begin
          state_nxt = IT_IDLE;
        end
      end
      default: begin
        state_nxt = IT_IDLE;
      end
    endcase
  end

  always_comb begin
    pop        = (state_r == IT_IDLE) && head_valid;
    done.valid = (state_r == IT_HOLD);
    done.count = iter_r;
  end

  always_comb begin
    zr_nxt   = zr_r;
    zi_nxt   = zi_r;
    cr_nxt   = cr_r;
    ci_nxt   = ci_r;
    sqr_nxt  = sqr_r;
    sqi_nxt  = sqi_r;
    xp_nxt   = xp_r;
    iter_nxt = iter_r;
    case (state_r)
      IT_IDLE: begin
        if (head_valid) begin
          iter_nxt = head_item.early ? 13'd1 : 13'd0;
          cr_nxt   = head_item.c_real[Z_W-1:0];
          ci_nxt   = head_item.c_imag[Z_W-1:0];
          sqr_nxt  = '0;
          sqi_nxt  = '0;
          xp_nxt   = '0;
        end
      end
      IT_ADD: begin
        // hold the count on a norm escape or at the limit
        if (!(esc_norm || at_lim)) begin
          iter_nxt = iter_r + 13'd1;
          zr_nxt   = zr_new[Z_W-1:0];
          zi_nxt   = zi_new[Z_W-1:0];
        end
      end
      IT_MUL: begin
        sqr_nxt = prod_rr[SQ_W-1:0];
        sqi_nxt = prod_ii[SQ_W-1:0];
        xp_nxt  = prod_ri[XP_W-1:0];
      end
      default: begin
        iter_nxt = iter_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IT_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zr_r  <= zr_nxt;
    zi_r  <= zi_nxt;
    cr_r  <= cr_nxt;
    ci_r  <= ci_nxt;
    sqr_r <= sqr_nxt;
    sqi_r <= sqi_nxt;
    xp_r  <= xp_nxt;
  end

endmodule

`default_nettype wire

[rtl/mec_div.sv]
// Restoring divider, one quotient bit per cycle; shared by all colour divisions.
// Depends on mec_pkg.
`default_nettype none

module mec_div import mec_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire mec_div_req_t req,
  output mec_div_rsp_t      rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [4:0]       step_r, step_nxt;
  logic [DIV_W-1:0] num_r, num_nxt;
  logic [DIV_W-1:0] quot_r, quot_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;

  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r, num_r[DIV_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    num_nxt  = num_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (busy_r) begin
      num_nxt  = {num_r[DIV_W-2:0], 1'b0};
      quot_nxt = {quot_r[DIV_W-2:0], fits};
      rem_nxt  = fits ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      step_nxt = step_r + 5'd1;
      if (step_r == 5'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      quot_nxt = '0;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

`default_nettype wire

[rtl/mec_shade.sv]
// Colour sequencer: grey level or palette entry from an escape count.
// Depends on mec_pkg and mec_div.
`default_nettype none

module mec_shade import mec_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mec_count_t        in_count,
  input  wire logic [ITER_W-1:0] lim,
  input  wire logic [1:0]        scheme,
  output logic                   ready,
  output mec_pixel_t             pixel
);

  shade_state_t         state_r, state_nxt;
  logic [ITER_W-1:0]    count_r, count_nxt;
  logic [ITER_W-1:0]    val_r, val_nxt;
  logic [ITER_W-1:0]    divv_r, divv_nxt;
  logic [RAD_W-1:0]     rad_r, rad_nxt;
  logic [ITER_W-1:0]    root_r, root_nxt;
  logic [SQREM_W-1:0]   rem_r, rem_nxt;
  logic [3:0]           step_r, step_nxt;
  logic [23:0]          rgb_r, rgb_nxt;

  logic [RAD_W-1:0]     rad_prod;
  logic [SQREM_W-1:0]   rem_sh;
  logic [SQREM_W-1:0]   trial;
  logic                 take;
  logic [ITER_W-1:0]    root_step;
  logic [DIV_W-1:0]     grey_num;
  logic [2*ITER_W-1:0]  stride_prod;
  logic [ITER_W-1:0]    stride;
  logic [3:0]           pal_idx;
  logic [7:0]           grey;
  mec_div_req_t         div_req;
  mec_div_rsp_t         div_rsp;

  mec_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign rad_prod = count_r * lim;

  // one root bit per cycle, two radicand bits at a time
  assign rem_sh    = {rem_r[SQREM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial     = {1'b0, root_r, 2'b01};
  assign take      = (rem_sh >= trial);
  assign root_step = {root_r[ITER_W-2:0], take};

  // palette stride lim / 14 by reciprocal multiplication
  assign stride_prod = lim * PAL_RECIP;
  assign stride      = ITER_W'(stride_prod >> PAL_RECIP_SH);

  // ceil(count*255/lim) as a floor division
  assign grey_num = ({7'd0, count_r} << 8) - {7'd0, count_r} + {7'd0, lim} - 20'd1;
  assign grey     = 8'd255 - div_rsp.quot[7:0];
  assign pal_idx  = (div_rsp.quot >= 20'(PAL_LAST)) ? PAL_LAST : div_rsp.quot[3:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SH_IDLE: begin
        if (in_count.valid) begin
          state_nxt = (scheme == SCHEME_SQRT) ? SH_PROD : SH_PICK;
        end
      end
      SH_PROD: begin
        state_nxt = SH_SQRT;
      end
      SH_SQRT: begin
        if (step_r == 4'(SQRT_STEPS - 1)) begin
          state_nxt = SH_PICK;
        end
      end
      SH_PICK: begin
        if (scheme inside {SCHEME_SQRT, SCHEME_LINEAR}) begin
          state_nxt = (val_r == lim) ? SH_OUT : SH_IDX_GO;
        end else begin
          state_nxt = SH_GREY_GO;
        end
      end
      SH_IDX_GO: begin
        state_nxt = SH_IDX_WAIT;
      end
      SH_IDX_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = SH_OUT;
        end
      end
      SH_GREY_GO: begin
        state_nxt = SH_GREY_WAIT;
      end
      SH_GREY_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = SH_OUT;
        end
      end
      SH_OUT: begin
        state_nxt = SH_IDLE;
      end
      default: begin
        state_nxt = SH_IDLE;
      end
    endcase
  end

  always_comb begin
    ready         = (state_r == SH_IDLE);
    div_req.start = 1'b0;
    div_req.num   = grey_num;
    div_req.den   = lim;
    case (state_r)
      SH_IDX_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {7'd0, val_r};
        div_req.den   = divv_r;
      end
      SH_GREY_GO: begin
        div_req.start = 1'b1;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
    pixel.valid = (state_r == SH_OUT);
    pixel.red   = rgb_r[23:16];
    pixel.green = rgb_r[15:8];
    pixel.blue  = rgb_r[7:0];
    pixel.count = count_r;
  end

  always_comb begin
    count_nxt = count_r;
    val_nxt   = val_r;
    divv_nxt  = divv_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    rgb_nxt   = rgb_r;
    case (state_r)
      SH_IDLE: begin
        if (in_count.valid) begin
          count_nxt = in_count.count;
          val_nxt   = in_count.count;
        end
      end
      SH_PROD: begin
        rad_nxt  = rad_prod;
        root_nxt = '0;
        rem_nxt  = '0;
        step_nxt = '0;
      end
      SH_SQRT: begin
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        rem_nxt  = take ? (rem_sh - trial) : rem_sh;
        root_nxt = root_step;
        step_nxt = step_r + 4'd1;
        if (step_r == 4'(SQRT_STEPS - 1)) begin
          val_nxt = root_step;
        end
      end
      SH_PICK: begin
        if (scheme inside {SCHEME_SQRT, SCHEME_LINEAR}) begin
          // hold the stride at one for small limits
          divv_nxt = (stride == '0) ? 13'd1 : stride;
          if (val_r == lim) begin
            rgb_nxt = pal_rgb(PAL_LAST);
          end
        end
      end
      SH_IDX_WAIT: begin
        if (div_rsp.done) begin
          rgb_nxt = pal_rgb(pal_idx);
        end
      end
      SH_GREY_WAIT: begin
        if (div_rsp.done) begin
          rgb_nxt = {grey, grey, grey};
        end
      end
      default: begin
        rgb_nxt = rgb_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SH_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    val_r   <= val_nxt;
    divv_r  <= divv_nxt;
    rad_r   <= rad_nxt;
    root_r  <= root_nxt;
    rem_r   <= rem_nxt;
    rgb_r   <= rgb_nxt;
  end

endmodule

`default_nettype wire

[rtl/mandelbrot_escape_colorizer_unit.sv]
// Top level of the escape-time colouriser: configuration registers, front end,
// queue, iteration engine and colour sequencer. Depends on mec_pkg and all mec_* modules.
//
// A point is taken when start is high and busy is low; busy rises only when the
// two-entry queue behind the front end is full. Points with a component beyond
// +/-2 skip iteration. Otherwise each step of z = z*z + c takes a multiply state
// (the three 31x31 products) followed by an add state (the add and escape test).
// Colouring then takes one division on the serial divider and, for the square-root
// palette, a bit-serial square root before it; a palette point that reaches the
// limit needs no division. Iteration of one point overlaps colouring of the
// previous one. Each result appears on the out_ ports for one cycle with out_valid
// high and must be taken then; results leave in the order the points arrived.
`default_nettype none
`include "mandelbrot_escape_colorizer_unit_defines.svh"

module mandelbrot_escape_colorizer_unit import mec_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [COORD_W-1:0] in_c_real,
  input  wire logic signed [COORD_W-1:0] in_c_imag,
  output logic                           out_valid,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [ITER_W-1:0]              out_escape_count,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [ITER_W-1:0]         cfg_wdata
);

  logic [ITER_W-1:0] max_iter_r, max_iter_nxt;
  logic [1:0]        scheme_r, scheme_nxt;
  logic [ITER_W-1:0] lim_eff;

  logic       push;
  mec_item_t  push_item;
  logic       queue_full;
  logic       head_valid;
  mec_item_t  head_item;
  logic       pop;
  logic       shade_ready;
  mec_count_t handoff;
  mec_pixel_t pixel;

  always_comb begin
    max_iter_nxt = max_iter_r;
    scheme_nxt   = scheme_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ITER:     max_iter_nxt = cfg_wdata;
        REG_COLOR_SCHEME: scheme_nxt   = cfg_wdata[1:0];
        default:          max_iter_nxt = max_iter_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= LIM_RESET;
      scheme_r   <= SCHEME_GREY;
    end else begin
      max_iter_r <= max_iter_nxt;
      scheme_r   <= scheme_nxt;
    end
  end

  // clamp the limit into its working range
  assign lim_eff = (max_iter_r < LIM_MIN) ? LIM_MIN :
                   (max_iter_r > LIM_MAX) ? LIM_MAX : max_iter_r;

  mec_front u_front (
    .start      (start),
    .in_c_real  (in_c_real),
    .in_c_imag  (in_c_imag),
    .queue_full (queue_full),
    .busy       (busy),
    .push       (push),
    .push_item  (push_item)
  );

  mec_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  mec_iter u_iter (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .lim         (lim_eff),
    .shade_ready (shade_ready),
    .done        (handoff)
  );

  mec_shade u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_count (handoff),
    .lim      (lim_eff),
    .scheme   (scheme_r),
    .ready    (shade_ready),
    .pixel    (pixel)
  );

  assign out_valid        = pixel.valid;
  assign out_red          = pixel.red;
  assign out_green        = pixel.green;
  assign out_blue         = pixel.blue;
  assign out_escape_count = pixel.count;

  `MEC_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held longer than one cycle")
  `MEC_ASSERT_IMPL(a_count_nonzero, out_valid, out_escape_count != '0, "escape count of zero delivered")
  `MEC_ASSERT_NEXT(a_handoff_hold, handoff.valid && !shade_ready, handoff.valid && $stable(handoff.count), "escape count dropped or changed while colour sequencer busy")

endmodule

`default_nettype wire
